@@ hw/rtl/mfw_pkg.sv @@
`default_nettype none

package mfw_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned WINDOW_DEF  = 3;
  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned ROWS_LIMIT  = 1024;
  localparam int unsigned ROW_W       = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_COLS = 1'b0,
    REG_IMAGE_ROWS = 1'b1
  } cfg_reg_e;

  typedef logic [DATA_W-1:0] pix_t;

endpackage

`default_nettype wire

@@ hw/rtl/mfw_median.sv @@
`default_nettype none

module mfw_median #(
  parameter int unsigned WINDOW = mfw_pkg::WINDOW_DEF
) (
  input  wire mfw_pkg::pix_t [WINDOW*WINDOW-1:0] win_i,
  output mfw_pkg::pix_t                          med_o
);
  import mfw_pkg::*;

  localparam int unsigned Area = WINDOW * WINDOW;
  localparam int unsigned Mid  = Area / 2;
  localparam int unsigned CntW = $clog2(Area + 1);

  logic [CntW-1:0] lt_cnt [Area];
  logic [CntW-1:0] le_cnt [Area];
  logic [Area-1:0] hit;

  // rank of each element: it is the median when the middle rank falls in [lt, le)
  always_comb begin
    for (int i = 0; i < Area; i++) begin
      lt_cnt[i] = '0;
      le_cnt[i] = '0;
      for (int j = 0; j < Area; j++) begin
        lt_cnt[i] = lt_cnt[i] + CntW'(win_i[j] < win_i[i]);
        le_cnt[i] = le_cnt[i] + CntW'(win_i[j] <= win_i[i]);
      end
      hit[i] = (lt_cnt[i] <= CntW'(Mid)) && (le_cnt[i] > CntW'(Mid));
    end
  end

  // all hits carry the same value, so an or-reduction selects it
  always_comb begin
    med_o = '0;
    for (int i = 0; i < Area; i++) begin
      med_o = med_o | (hit[i] ? win_i[i] : '0);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/median_filter_window_unit.sv @@
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata[7:0] sample_in
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata[7:0] median_out, tlast frame_last
// cfg       in   cfg_we_i (no ready)             cfg_idx_i, cfg_data_i[10:0]
//
// one sample per cycle unless the output is stalled; a result passes the window registers and the output register
// after reset the line store is zeroed one column per cycle,
// during which s_axis_tready stays low (config writes are taken)
// the line store is one memory with registered read, prefetching the next column
// a stalled output holds one result in the output register and one in the window stage

`default_nettype none

module median_filter_window_unit #(
  parameter int unsigned WINDOW   = mfw_pkg::WINDOW_DEF,
  parameter int unsigned MAX_COLS = mfw_pkg::MAX_COLS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [7:0]                     s_axis_tdata,   // [7:0] sample_in
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] median_out
  output logic                           m_axis_tlast,
  input  wire                            cfg_we_i,
  input  wire  [mfw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [mfw_pkg::CFG_W-1:0]      cfg_data_i
);
  import mfw_pkg::*;

  localparam int unsigned LineLen = MAX_COLS + WINDOW - 1;
  localparam int unsigned AW      = $clog2(LineLen);
  localparam int unsigned CW      = AW + 1;
  localparam int unsigned Lines   = WINDOW - 1;
  localparam int unsigned Area    = WINDOW * WINDOW;

  // configuration
  logic [CFG_W-1:0] cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_RESET;
      rows_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_COLS: cols_q <= cfg_data_i;
        REG_IMAGE_ROWS: rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CW-1:0]    pad_w;
  logic [ROW_W-1:0] pad_h;

  always_comb begin
    if (cols_q == '0)                  pad_w = CW'(1 + WINDOW - 1);
    else if (int'(cols_q) > MAX_COLS)  pad_w = CW'(MAX_COLS + WINDOW - 1);
    else                               pad_w = CW'(cols_q) + CW'(WINDOW - 1);
    if (rows_q == '0)                  pad_h = ROW_W'(1 + WINDOW - 1);
    else if (int'(rows_q) > ROWS_LIMIT) pad_h = ROW_W'(ROWS_LIMIT + WINDOW - 1);
    else                               pad_h = rows_q + ROW_W'(WINDOW - 1);
  end

  // handshake and raster position
  logic              clr_busy_q, clr_busy_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic [AW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              s1_v_q, s1_v_d, s1_last_q, s1_last_d;
  logic              out_v_q, out_v_d, out_last_q, out_last_d;
  pix_t              out_med_q, out_med_d;
  logic              out_free, accept, produce, frame_end, col_end, row_end;
  logic [CW-1:0]     col_inc;
  logic [ROW_W-1:0]  row_inc;

  assign out_free      = !out_v_q || m_axis_tready;
  assign s_axis_tready = !clr_busy_q && (!s1_v_q || out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign col_inc   = CW'(col_q) + CW'(1);
  assign row_inc   = row_q + ROW_W'(1);
  assign col_end   = col_inc >= pad_w;
  assign row_end   = row_inc >= pad_h;
  assign produce   = (row_q >= ROW_W'(WINDOW - 1)) && (CW'(col_q) >= CW'(WINDOW - 1));
  assign frame_end = col_end && row_end;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_inc;
      end else begin
        col_d = col_inc[AW-1:0];
      end
    end
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(LineLen - 1)) clr_busy_d = 1'b0;
    end
  end

  // line store: one word per padded column, oldest line in the lowest byte
  logic [Lines-1:0][DATA_W-1:0] mem [LineLen];
  logic [Lines-1:0][DATA_W-1:0] rd_q, wr_data;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic                         wr_en;

  always_comb begin
    for (int k = 0; k < Lines - 1; k++) wr_data[k] = rd_q[k+1];
    wr_data[Lines-1] = s_axis_tdata;
    if (clr_busy_q) wr_data = '0;
  end

  assign wr_en   = clr_busy_q || accept;
  assign wr_addr = clr_busy_q ? clr_addr_q : col_q;
  // fetch the column of the next item ahead of time
  assign rd_addr = accept ? col_d : col_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // window registers, oldest row first, newest column last
  pix_t [WINDOW-1:0][WINDOW-1:0] win_q, win_d;
  pix_t [Area-1:0]               win_flat;
  pix_t                          med;

  always_comb begin
    win_d = win_q;
    if (accept) begin
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW - 1; c++) win_d[r][c] = win_q[r][c+1];
      end
      for (int r = 0; r < Lines; r++) win_d[r][WINDOW-1] = rd_q[r];
      win_d[WINDOW-1][WINDOW-1] = s_axis_tdata;
    end
  end

  always_comb begin
    for (int r = 0; r < WINDOW; r++) begin
      for (int c = 0; c < WINDOW; c++) win_flat[r*WINDOW+c] = win_q[r][c];
    end
  end

  mfw_median #(.WINDOW(WINDOW)) u_median (
    .win_i (win_flat),
    .med_o (med)
  );

  always_comb begin
    s1_v_d    = s1_v_q;
    s1_last_d = s1_last_q;
    if (accept) begin
      s1_v_d    = produce;
      s1_last_d = frame_end;
    end else if (out_free) begin
      s1_v_d = 1'b0;
    end
    out_v_d    = out_v_q;
    out_med_d  = out_med_q;
    out_last_d = out_last_q;
    if (out_free) begin
      out_v_d    = s1_v_q;
      out_med_d  = med;
      out_last_d = s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_v_q     <= 1'b0;
      s1_last_q  <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      win_q      <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_v_q     <= s1_v_d;
      s1_last_q  <= s1_last_d;
      out_v_q    <= out_v_d;
      out_last_q <= out_last_d;
      win_q      <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_med_q <= out_med_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_med_q;
  assign m_axis_tlast  = out_last_q;

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !accept)
    else $error("item accepted during line store clearing");

  a_held_result_not_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !m_axis_tready) |=> ($stable(win_q) && s1_v_q))
    else $error("window stage overwritten while output stalled");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(col_q) < LineLen)
    else $error("column counter beyond line store");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < ROWS_LIMIT + WINDOW - 1)
    else $error("row counter beyond padded frame");

endmodule

`default_nettype wire

@@ bench/median_filter_window_unit_tb.sv @@
`timescale 1ns / 1ps

module median_filter_window_unit_tb;
  import mfw_pkg::*;

  localparam int unsigned WIN           = WINDOW_DEF;
  localparam int unsigned LINE_LEN      = MAX_COLS_DEF + WIN - 1;
  localparam int unsigned MID_RANK      = WIN * WIN / 2;
  localparam int unsigned RAND_ITEMS    = 950;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    pix_t median;
    logic last;
  } median_res_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  pix_t             s_axis_tdata  = '0;   // [7:0] sample_in
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  pix_t             m_axis_tdata;         // [7:0] median_out
  logic             m_axis_tlast;
  logic             cfg_we_i      = 1'b0;
  cfg_reg_e         cfg_idx_i     = REG_IMAGE_COLS;
  logic [CFG_W-1:0] cfg_data_i    = '0;

  // predictor state
  pix_t             row_hist [WIN-1][LINE_LEN];
  pix_t             win_px [WIN][WIN];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [CFG_W-1:0] cols_reg;
  logic [CFG_W-1:0] rows_reg;

  pix_t             pixel_q[$];
  median_res_t      pending_medians[$];

  bit               s_fire      = 1'b0;
  bit               idle_en     = 1'b1;
  int               src_gap     = 0;
  int               sink_gap    = 0;
  int               sink_hold   = 0;
  int unsigned      err_cnt     = 0;
  int unsigned      items_taken = 0;
  int unsigned      medians_seen = 0;
  int unsigned      frames_seen = 0;
  int unsigned      reg_writes  = 0;
  longint unsigned  cycle_cnt   = 0;

  median_filter_window_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_model();
    int r;
    int c;
    for (r = 0; r < WIN - 1; r++) begin
      for (c = 0; c < LINE_LEN; c++) row_hist[r][c] = '0;
    end
    for (r = 0; r < WIN; r++) begin
      for (c = 0; c < WIN; c++) win_px[r][c] = '0;
    end
    col_pos  = 0;
    row_pos  = 0;
    cols_reg = CFG_RESET;
    rows_reg = CFG_RESET;
  endfunction

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned cap);
    int unsigned w;
    w = 32'(v);
    if (w == 0) return 1;
    if (w > cap) return cap;
    return w;
  endfunction

  function automatic int unsigned padded_w();
    return clamp_dim(cols_reg, MAX_COLS_DEF) + WIN - 1;
  endfunction

  function automatic int unsigned padded_h();
    return clamp_dim(rows_reg, ROWS_LIMIT) + WIN - 1;
  endfunction

  // samples still needed until the next frame starts
  function automatic int unsigned pixels_to_frame_end();
    int unsigned line_rest;
    line_rest = (col_pos >= padded_w()) ? 1 : padded_w() - col_pos;
    if (row_pos + 1 >= padded_h()) return line_rest;
    return line_rest + (padded_h() - row_pos - 1) * padded_w();
  endfunction

  // median by rank: the value with at most MID_RANK smaller entries and more than MID_RANK entries not larger
  function automatic pix_t window_median();
    pix_t flat [WIN*WIN];
    int   i;
    int   j;
    int   below;
    int   upto;
    for (i = 0; i < WIN * WIN; i++) flat[i] = win_px[i / WIN][i % WIN];
    for (i = 0; i < WIN * WIN; i++) begin
      below = 0;
      upto  = 0;
      for (j = 0; j < WIN * WIN; j++) begin
        if (flat[j] < flat[i]) below++;
        if (flat[j] <= flat[i]) upto++;
      end
      if (below <= MID_RANK && upto > MID_RANK) return flat[i];
    end
    return '0;
  endfunction

  function automatic void shift_in_sample(pix_t px);
    pix_t        column [WIN];
    median_res_t res;
    int unsigned pw;
    int unsigned ph;
    int          k;
    int          r;
    int          c;
    pw = padded_w();
    ph = padded_h();
    if (col_pos < LINE_LEN) begin
      for (k = 0; k < WIN - 1; k++) column[k] = row_hist[k][col_pos];
      for (k = 0; k < WIN - 2; k++) row_hist[k][col_pos] = row_hist[k+1][col_pos];
      row_hist[WIN-2][col_pos] = px;
    end else begin
      for (k = 0; k < WIN - 1; k++) column[k] = '0;
    end
    column[WIN-1] = px;
    for (r = 0; r < WIN; r++) begin
      for (c = 0; c < WIN - 1; c++) win_px[r][c] = win_px[r][c+1];
      win_px[r][WIN-1] = column[r];
    end
    if (row_pos >= WIN - 1 && col_pos >= WIN - 1) begin
      res.median = window_median();
      res.last   = (row_pos + 1 >= ph) && (col_pos + 1 >= pw);
      pending_medians.push_back(res);
    end
    if (col_pos + 1 >= pw) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= ph) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic logic [CFG_W-1:0] random_dim(int unsigned typical, int unsigned wide);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'($urandom_range(typical + 1, wide));
      default: return CFG_W'($urandom_range(1, typical));
    endcase
  endfunction

  // random content with the two extremes favored
  function automatic void queue_pixels(int unsigned n);
    int unsigned sel;
    repeat (n) begin
      sel = $urandom_range(0, 7);
      if (sel == 0) pixel_q.push_back(8'h00);
      else if (sel == 1) pixel_q.push_back(8'hFF);
      else pixel_q.push_back(pix_t'($urandom_range(0, 255)));
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_cnt++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == REG_IMAGE_COLS) cols_reg = val;
    else rows_reg = val;
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // samples that end a line can leave the pipe busy, so settle after the queues drain
  task automatic wait_idle();
    while (pixel_q.size() != 0 || pending_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // input side: record accepted items and advance the predictor
  always @(posedge clk_i) begin
    s_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (s_fire) begin
      shift_in_sample(s_axis_tdata);
      void'(pixel_q.pop_front());
      items_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || s_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel_q[0];
        if (idle_en && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 15);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: an optional long hold, otherwise random stall bursts
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_en && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 15);
    end
  end

  always @(posedge clk_i) begin
    median_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      medians_seen++;
      if (m_axis_tlast) frames_seen++;
      if (pending_medians.size() == 0) begin
        report_mismatch($sformatf("median %0d with none expected", m_axis_tdata));
      end else begin
        want = pending_medians.pop_front();
        if (m_axis_tdata !== want.median)
          report_mismatch($sformatf("median %0d, expected %0d", m_axis_tdata, want.median));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("frame end flag %b, expected %b", m_axis_tlast, want.last));
      end
    end
  end

  initial begin
    pix_t        corner_px [7];
    int unsigned rand_items;
    int unsigned span;
    int unsigned cut;
    int          i;

    corner_px = '{8'h01, 8'h80, 8'hFE, 8'h7F, 8'hFF, 8'h00, 8'h55};
    clear_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero acts as one: smallest frame, a single flagged median
    write_reg(REG_IMAGE_COLS, '0);
    write_reg(REG_IMAGE_ROWS, '0);
    for (i = 0; i < 9; i++) pixel_q.push_back((i % 2) ? 8'h00 : 8'hFF);
    wait_idle();

    // narrow the width while the column counter sits past the new bound
    write_reg(REG_IMAGE_COLS, CFG_W'(2));
    write_reg(REG_IMAGE_ROWS, CFG_W'(2));
    foreach (corner_px[k]) pixel_q.push_back(corner_px[k]);
    wait_idle();
    write_reg(REG_IMAGE_COLS, '0);
    queue_pixels(pixels_to_frame_end());
    wait_idle();

    // row register above range, then cut back while the row counter is past it
    write_reg(REG_IMAGE_COLS, CFG_W'(1));
    write_reg(REG_IMAGE_ROWS, '1);
    queue_pixels(3 * 10);
    wait_idle();
    write_reg(REG_IMAGE_ROWS, CFG_W'(3));
    queue_pixels(pixels_to_frame_end());
    wait_idle();

    // sink holds off for a long stretch while a full frame keeps coming
    write_reg(REG_IMAGE_COLS, CFG_W'(6));
    write_reg(REG_IMAGE_ROWS, CFG_W'(4));
    queue_pixels(pixels_to_frame_end());
    sink_hold = 300;
    wait_idle();

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      write_reg(REG_IMAGE_COLS, random_dim(8, 24));
      write_reg(REG_IMAGE_ROWS, random_dim(5, 10));
      span = pixels_to_frame_end() + $urandom_range(0, 1) * padded_w() * padded_h();
      if ($urandom_range(0, 4) == 0) begin
        // break off partway, retune and finish whatever frame follows
        cut = $urandom_range(1, span);
        queue_pixels(cut);
        wait_idle();
        write_reg(REG_IMAGE_COLS, random_dim(8, 24));
        write_reg(REG_IMAGE_ROWS, random_dim(5, 10));
        span = cut + pixels_to_frame_end();
        queue_pixels(span - cut);
      end else begin
        queue_pixels(span);
      end
      rand_items += span;
      if (rand_items + 200 > RAND_ITEMS) idle_en = 1'b0;
    end
    wait_idle();

    $display("covered %0d samples, %0d medians, %0d frame ends, %0d register writes",
             items_taken, medians_seen, frames_seen, reg_writes);
    $display("frames from one pixel to 24 wide, zero and oversized registers, mid-frame changes");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
